@@ rtl/core/rational_arithmetic_unit_assert.svh @@
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/rau_pkg.sv @@
package rau_pkg;
   localparam logic [3:0] ACT_NORM = 4'd0;
   localparam logic [3:0] ACT_ADD  = 4'd1;
   localparam logic [3:0] ACT_SUB  = 4'd2;
   localparam logic [3:0] ACT_MUL  = 4'd3;
   localparam logic [3:0] ACT_DIV  = 4'd4;
   localparam logic [3:0] ACT_NEG  = 4'd5;
   localparam logic [3:0] ACT_LT   = 4'd6;
   localparam logic [3:0] ACT_GT   = 4'd7;
   localparam logic [3:0] ACT_EQ   = 4'd8;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ZERO_DEN = 3'd1;
   localparam logic [2:0] ST_DIV_ZERO = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_BAD      = 3'd4;

   typedef struct packed {
      logic [3:0]  action;
      logic [31:0] x_numerator;
      logic [31:0] x_denominator;
      logic [31:0] y_numerator;
      logic [31:0] y_denominator;
   } req_type;

   typedef struct packed {
      logic [31:0] res_numerator;
      logic [30:0] res_denominator;
      logic        compare_true;
      logic [2:0]  status;
   } rsp_type;
endpackage

@@ rtl/core/rau_if.sv @@
interface rau_req_if;
   import rau_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rau_rsp_if;
   import rau_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/rau_gcd.sv @@
// Binary gcd of two 64-bit magnitudes, one step per cycle
module rau_gcd (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a_in,
   input  logic [63:0] b_in,
   output logic        done,
   output logic [63:0] gcd
);
   logic [63:0] a_ff, a_in_n, b_ff, b_in_n;
   logic [6:0]  k_ff, k_in;
   logic        busy_ff, busy_in;
   logic [63:0] diff;

   always_comb begin
      a_in_n = a_ff;
      b_in_n = b_ff;
      k_in = k_ff;
      busy_in = busy_ff;
      diff = (a_ff > b_ff) ? a_ff - b_ff : b_ff - a_ff;
      if (start) begin
         a_in_n = a_in;
         b_in_n = b_in;
         k_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff == 64'd0 || b_ff == 64'd0 || a_ff == b_ff) begin
            busy_in = 1'b0;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in_n = a_ff >> 1;
            b_in_n = b_ff >> 1;
            k_in = k_ff + 7'd1;
         end else if (!a_ff[0]) begin
            a_in_n = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in_n = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in_n = diff >> 1;
         end else begin
            b_in_n = diff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff <= a_in_n;
      b_ff <= b_in_n;
      k_ff <= k_in;
   end

   assign done = busy_ff && (a_ff == 64'd0 || b_ff == 64'd0 || a_ff == b_ff) && !start;
   assign gcd = ((a_ff == 64'd0) ? b_ff : a_ff) << k_ff[5:0];
endmodule

@@ rtl/core/rau_div.sv @@
// Restoring divider, 64-bit quotient, one bit per cycle
module rau_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff, q_ff[63]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
         end else begin
            if (!trial[64]) begin
               r_in = trial[63:0];
               q_in = {q_ff[62:0], 1'b1};
            end else begin
               r_in = {r_ff[62:0], q_ff[63]};
               q_in = {q_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
   end

   assign done = busy_ff && cnt_ff == 7'd0 && !start;
   assign quotient = q_ff;
endmodule

@@ rtl/core/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: one request at a time. The four cross products are
// formed in turn on one shared 32x32 signed multiplier; reduction then runs a
// binary gcd and two restoring divisions on one shared divider. Comparisons
// and error cases skip the gcd and the divisions. The response is held in an
// output register until taken.
module rational_arithmetic_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);
   import rau_pkg::*;
   `include "rational_arithmetic_unit_assert.svh"

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL  = 4'd1;
   localparam logic [3:0] S_COMB = 4'd2;
   localparam logic [3:0] S_GCD  = 4'd3;
   localparam logic [3:0] S_DIVN = 4'd4;
   localparam logic [3:0] S_DIVD = 4'd5;
   localparam logic [3:0] S_OUT  = 4'd6;
   localparam logic [63:0] HALF = 64'd1 << (VALUE_WIDTH - 1);

   logic [3:0]  state_ff, state_in;
   logic [3:0]  act_ff;
   logic signed [63:0] xn_ff, xd_ff, yn_ff, yd_ff;
   logic signed [63:0] p_ff [4];
   logic [1:0]  mi_ff, mi_in;
   logic signed [63:0] n_ff, n_in, d_ff, d_in;
   logic [63:0] an_ff, an_in, g_ff, g_in;
   logic        neg_ff, neg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic signed [63:0] ma, mb, mprod;
   logic        g_start, g_done, dv_start, dv_done;
   logic [63:0] g_res, dv_q, dv_a, dv_b, mn, md;
   logic signed [63:0] xn_w, xd_w, yn_w, yd_w;
   logic        bad;
   logic        launch_ff;

   function automatic logic signed [63:0] sx(input logic [31:0] v);
      logic signed [63:0] r;
      r = 64'($signed(v[VALUE_WIDTH-1:0]));
      return r;
   endfunction

   assign xn_w = sx(req.payload.x_numerator);
   assign xd_w = sx(req.payload.x_denominator);
   assign yn_w = sx(req.payload.y_numerator);
   assign yd_w = sx(req.payload.y_denominator);

   always_comb begin
      unique case (mi_ff)
         2'd0: begin ma = xn_ff; mb = yd_ff; end
         2'd1: begin ma = yn_ff; mb = xd_ff; end
         2'd2: begin ma = xn_ff; mb = yn_ff; end
         default: begin ma = xd_ff; mb = yd_ff; end
      endcase
   end
   assign mprod = 64'($signed(ma[31:0]) * $signed(mb[31:0]));

   assign mn = n_ff[63] ? 64'(-n_ff) : 64'(n_ff);
   assign md = d_ff[63] ? 64'(-d_ff) : 64'(d_ff);
   assign dv_a = (state_ff == S_DIVN) ? mn : md;
   assign dv_b = g_ff;

   // launch the gcd or the divider in the first cycle of its state
   assign g_start = launch_ff && state_ff == S_GCD;
   assign dv_start = launch_ff && (state_ff == S_DIVN || state_ff == S_DIVD);

   rau_gcd u_gcd (.clock(clock), .reset(reset), .start(g_start), .a_in(mn), .b_in(md),
      .done(g_done), .gcd(g_res));
   rau_div u_div (.clock(clock), .reset(reset), .start(dv_start), .dividend(dv_a),
      .divisor(dv_b), .done(dv_done), .quotient(dv_q));

   always_comb begin
      state_in = state_ff;
      mi_in = mi_ff;
      n_in = n_ff;
      d_in = d_ff;
      an_in = an_ff;
      g_in = g_ff;
      neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      bad = (act_ff > ACT_EQ) || xd_ff <= 0 || (act_ff != ACT_NEG && yd_ff <= 0);
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && !rsp_valid_ff) begin
               state_in = S_MUL;
               mi_in = 2'd0;
            end
         end
         S_MUL: begin
            mi_in = mi_ff + 2'd1;
            if (mi_ff == 2'd3) state_in = S_COMB;
         end
         S_COMB: begin
            rsp_in = '0;
            state_in = S_OUT;
            if (act_ff == ACT_NORM) begin
               if (xd_ff == 0) rsp_in.status = ST_ZERO_DEN;
               else begin
                  n_in = xn_ff; d_in = xd_ff; state_in = S_GCD;
               end
            end else if (bad) begin
               rsp_in.status = ST_BAD;
            end else begin
               case (act_ff)
                  ACT_ADD: begin n_in = p_ff[0] + p_ff[1]; d_in = p_ff[3];
                     state_in = S_GCD; end
                  ACT_SUB: begin n_in = p_ff[0] - p_ff[1]; d_in = p_ff[3];
                     state_in = S_GCD; end
                  ACT_MUL: begin n_in = p_ff[2]; d_in = p_ff[3]; state_in = S_GCD; end
                  ACT_DIV: begin
                     if (yn_ff == 0) rsp_in.status = ST_DIV_ZERO;
                     else begin
                        n_in = p_ff[0]; d_in = p_ff[1]; state_in = S_GCD;
                     end
                  end
                  ACT_NEG: begin n_in = -xn_ff; d_in = xd_ff; state_in = S_GCD; end
                  ACT_LT: rsp_in.compare_true = p_ff[0] < p_ff[1];
                  ACT_GT: rsp_in.compare_true = p_ff[1] < p_ff[0];
                  default: rsp_in.compare_true = p_ff[0] == p_ff[1];
               endcase
            end
            if (state_in == S_OUT) rsp_valid_in = 1'b1;
            if (state_in == S_GCD) begin
               if (n_in == 0) begin
                  rsp_in.res_denominator = 31'd1;
                  state_in = S_OUT;
                  rsp_valid_in = 1'b1;
               end else begin
                  neg_in = n_in[63] != d_in[63];
               end
            end
         end
         S_GCD: begin
            if (g_done) begin
               g_in = g_res;
               state_in = S_DIVN;
            end
         end
         S_DIVN: begin
            if (dv_done) begin
               an_in = dv_q;
               state_in = S_DIVD;
            end
         end
         S_DIVD: begin
            if (dv_done) begin
               rsp_in = '0;
               if (dv_q > HALF - 64'd1 || an_ff > (neg_ff ? HALF : HALF - 64'd1)) begin
                  rsp_in.status = ST_OVERFLOW;
               end else begin
                  rsp_in.res_numerator = neg_ff ? 32'(-an_ff) : an_ff[31:0];
                  rsp_in.res_denominator = dv_q[30:0];
               end
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= 1'b0;
      end else begin
         launch_ff <= (state_ff != state_in) &&
                      (state_in == S_GCD || state_in == S_DIVN || state_in == S_DIVD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == S_IDLE && req.valid && !rsp_valid_ff) begin
         act_ff <= req.payload.action;
         xn_ff <= xn_w;
         xd_ff <= xd_w;
         yn_ff <= yn_w;
         yd_ff <= yd_w;
      end
      if (state_ff == S_MUL) p_ff[mi_ff] <= mprod;
      mi_ff <= mi_in;
      n_ff <= n_in;
      d_ff <= d_in;
      an_ff <= an_in;
      g_ff <= g_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   assign req.ready = state_ff == S_IDLE && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   `RAU_ASSERT_IMPL(a_ready_idle, clock, reset, req.ready, state_ff == S_IDLE)
   `RAU_ASSERT_NEXT(a_accept_mul, clock, reset, req.valid && req.ready, state_ff == S_MUL)
   `RAU_ASSERT_IMPL(a_err_zero, clock, reset, rsp.valid && rsp.payload.status != ST_OK,
      rsp.payload.res_numerator == 0 && rsp.payload.compare_true == 1'b0)
endmodule

@@ bench/rational_arithmetic_unit_test.sv @@
module rational_arithmetic_unit_test;
   import rau_pkg::*;

   localparam int WAIT_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_COUNT = 1530;
   localparam int HOLD_CYCLES = 1500;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rau_req_if req_ch();
   rau_rsp_if rsp_ch();

   rational_arithmetic_unit #(.VALUE_WIDTH(32)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   req_type pending_requests[$];
   rsp_type expected_answers[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned take_idle_pct = 0;
   bit hold_active = 1'b0;
   bit send_paused = 1'b0;
   event hold_start;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // reduce n/d; returns overflow status when the reduced value leaves 32 bits
   function automatic rsp_type reduce_fraction(input longint n, input longint d);
      rsp_type r;
      logic [63:0] an, ad, g;
      bit neg;
      r = '0;
      if (n == 0) begin
         r.res_denominator = 31'd1;
         return r;
      end
      an = (n < 0) ? 64'(-n) : 64'(n);
      ad = (d < 0) ? 64'(-d) : 64'(d);
      g = gcd64(an, ad);
      an = an / g;
      ad = ad / g;
      neg = (n < 0) != (d < 0);
      if (ad > 64'h7FFF_FFFF || an > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
         r.status = ST_OVERFLOW;
         return r;
      end
      r.res_numerator = neg ? 32'(-an) : an[31:0];
      r.res_denominator = ad[30:0];
      return r;
   endfunction

   function automatic rsp_type fraction_result(input req_type q);
      rsp_type r;
      longint xn, xd, yn, yd;
      r = '0;
      xn = longint'(signed'(q.x_numerator));
      xd = longint'(signed'(q.x_denominator));
      yn = longint'(signed'(q.y_numerator));
      yd = longint'(signed'(q.y_denominator));
      if (q.action == ACT_NORM) begin
         if (xd == 0) r.status = ST_ZERO_DEN;
         else r = reduce_fraction(xn, xd);
      end else if (q.action > ACT_EQ) begin
         r.status = ST_BAD;
      end else if (xd <= 0 || (q.action != ACT_NEG && yd <= 0)) begin
         r.status = ST_BAD;
      end else begin
         case (q.action)
            ACT_ADD: r = reduce_fraction(xn * yd + yn * xd, xd * yd);
            ACT_SUB: r = reduce_fraction(xn * yd - yn * xd, xd * yd);
            ACT_MUL: r = reduce_fraction(xn * yn, xd * yd);
            ACT_DIV: begin
               if (yn == 0) r.status = ST_DIV_ZERO;
               else r = reduce_fraction(xn * yd, xd * yn);
            end
            ACT_NEG: r = reduce_fraction(-xn, xd);
            ACT_LT: r.compare_true = (xn * yd < yn * xd);
            ACT_GT: r.compare_true = (yn * xd < xn * yd);
            default: r.compare_true = (xn * yd == yn * xd);
         endcase
      end
      if (r.status != ST_OK) r = '{default: '0, status: r.status};
      return r;
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'($urandom_range(0, 20)) - 32'd10;
         1: return 32'h8000_0000 + 32'($urandom_range(0, 2));
         2: return 32'h7FFF_FFFF - 32'($urandom_range(0, 2));
         3: return 32'($urandom_range(0, 2000)) - 32'd1000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] random_positive();
      logic [31:0] v;
      v = random_value();
      v[31] = 1'b0;
      if (v == 0) v = 32'd1;
      return v;
   endfunction

   function automatic req_type random_request();
      req_type q;
      q.action = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) :
                 4'($urandom_range(ACT_NORM, ACT_EQ));
      q.x_numerator = random_value();
      q.y_numerator = random_value();
      // mostly well-formed operands, some broken denominators
      if ($urandom_range(0, 9) == 0) begin
         q.x_denominator = random_value();
         q.y_denominator = random_value();
      end else begin
         q.x_denominator = random_positive();
         q.y_denominator = random_positive();
      end
      if (q.action == ACT_NORM && $urandom_range(0, 2) == 0) q.x_denominator = random_value();
      return q;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_answers.push_back(fraction_result(req_ch.payload));
            void'(pending_requests.pop_front());
         end
         if (pending_requests.size() > 0 && !send_paused &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= pending_requests[0];
         end else if (!(req_ch.valid && !req_ch.ready)) begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // hold off the response side for a long stretch
   always begin
      @(hold_start);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_ch.payload.res_numerator != want.res_numerator)
                  report_mismatch("res_numerator", signed'(rsp_ch.payload.res_numerator),
                                  signed'(want.res_numerator));
               if (rsp_ch.payload.res_denominator != want.res_denominator)
                  report_mismatch("res_denominator", rsp_ch.payload.res_denominator,
                                  want.res_denominator);
               if (rsp_ch.payload.compare_true != want.compare_true)
                  report_mismatch("compare_true", rsp_ch.payload.compare_true,
                                  want.compare_true);
               if (rsp_ch.payload.status != want.status)
                  report_mismatch("status", rsp_ch.payload.status, want.status);
            end
         end
         if (hold_active) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
         end
      end
      if (cycle_count > WAIT_LIMIT) begin
         $display("** rational_arithmetic_unit: FAILED **");
         $finish;
      end
   end

   task automatic add_request(input logic [3:0] act, input int xn, input int xd,
                              input int yn, input int yd);
      pending_requests.push_back('{act, xn, xd, yn, yd});
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_ch.valid || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every action, each error case
      add_request(ACT_NORM, 6, -4, 0, 1);
      add_request(ACT_NORM, 0, -7, 0, 1);
      add_request(ACT_NORM, 5, 0, 0, 1);
      add_request(ACT_NORM, 32'h8000_0000, -1, 0, 1);
      add_request(ACT_NORM, 32'h8000_0000, 32'h8000_0000, 0, 1);
      add_request(ACT_NORM, 1, 32'h8000_0000, 0, 1);
      add_request(ACT_ADD, 1, 2, 1, 3);
      add_request(ACT_ADD, 32'h7FFF_FFFF, 1, 1, 1);
      add_request(ACT_SUB, 1, 2, 1, 2);
      add_request(ACT_SUB, 32'h8000_0000, 1, 1, 1);
      add_request(ACT_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
      add_request(ACT_MUL, 3, 32'h7FFF_FFFF, -5, 32'h7FFF_FFFE);
      add_request(ACT_DIV, 1, 2, 0, 5);
      add_request(ACT_DIV, 3, 4, -9, 8);
      add_request(ACT_DIV, 32'h8000_0000, 1, -1, 1);
      add_request(ACT_NEG, 32'h8000_0000, 1, 0, 0);
      add_request(ACT_NEG, 32'h7FFF_FFFF, 7, 0, -1);
      add_request(ACT_LT, 1, 3, 1, 2);
      add_request(ACT_GT, 1, 3, 1, 2);
      add_request(ACT_EQ, 2, 4, 1, 2);
      add_request(ACT_ADD, 1, 0, 1, 1);
      add_request(ACT_LT, 1, 1, 1, -1);
      add_request(4'd15, -1, -1, -1, -1);
      add_request(4'd9, 0, 1, 0, 1);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 63 : 0;
         take_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 17 : 0;
         for (int i = 0; i < RANDOM_COUNT / 3; i++) begin
            pending_requests.push_back(random_request());
            if (i == 40) begin
               // hold the response side so the unit backs up its input
               while (pending_requests.size() > 5) @(posedge clock);
               -> hold_start;
            end
            if (i == 200) begin
               // wait until every response has come back, then pause the sender
               wait_drained();
               send_paused = 1'b1;
               repeat (30) @(posedge clock);
               send_paused = 1'b0;
            end
         end
         wait_drained();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0)
         $display("** rational_arithmetic_unit: PASSED **");
      else
         $display("** rational_arithmetic_unit: FAILED **");
      $finish;
   end
endmodule
